// ===== sv/asi_pkg.sv =====
`timescale 1ns / 1ps

package asi_pkg;

	// Field widths of the request and result items
	localparam int KIND_W    = 3;
	localparam int POS_W     = 5;
	localparam int VALUE_W   = 32;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TUSER_W = 2;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

	// RAM read address sources
	typedef enum logic [1:0] {
		RA_BELOW_TOP,   // count - 1
		RA_POS,         // count - position
		RA_SHIFT        // shift index - 2
	} raddr_sel_t;

	// RAM write address sources
	typedef enum logic [1:0] {
		WA_TOP,         // count
		WA_POS,         // count - position
		WA_SHIFT,       // shift index
		WA_SLOT         // count + 1 - position
	} waddr_sel_t;

	// RAM write data sources
	typedef enum logic {
		WD_VALUE,
		WD_RAM
	} wdata_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                load_req;
		logic                ram_we;
		waddr_sel_t          wa_sel;
		wdata_sel_t          wd_sel;
		raddr_sel_t          ra_sel;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                idx_init;
		logic                idx_dec;
		logic                res_load;
		logic                res_from_ram;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              full;
		logic              empty;
		logic              pos_ok;
		logic              pos_one;
		logic              shift_last;
	} stat_t;

endpackage

// ===== sv/asi_ram.sv =====
`timescale 1ns / 1ps

module asi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/asi_datapath.sv =====
`timescale 1ns / 1ps

module asi_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asi_pkg::cmd_t                 cmd,
	output asi_pkg::stat_t                st,
	input  logic [asi_pkg::KIND_W-1:0]    kind,
	input  logic [asi_pkg::POS_W-1:0]     position,
	input  logic [asi_pkg::VALUE_W-1:0]   value,
	output logic [asi_pkg::DATA_W-1:0]    data,
	output logic [asi_pkg::STATUS_W-1:0]  status,
	output logic [asi_pkg::COUNT_W-1:0]   count
);

	import asi_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [KIND_W-1:0]   kind_q;
	logic [POS_W-1:0]    pos_q;
	logic [VALUE_W-1:0]  value_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [DATA_W-1:0]   data_q;
	logic [STATUS_W-1:0] status_q;

	logic [CMPW-1:0]     count_ext;
	logic [CMPW-1:0]     pos_ext;
	logic [CMPW-1:0]     idx_ext;
	logic [CMPW-1:0]     pos_diff;
	logic [CMPW-1:0]     slot;
	logic [CW-1:0]       count_m1;
	logic [CW-1:0]       idx_m2;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [VALUE_W-1:0]  wdata;
	logic [VALUE_W-1:0]  rdata;

	// Hold the request fields for the whole operation
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q  <= kind;
			pos_q   <= position;
			value_q <= value;
		end
	end

	// Track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Step the insert shift index down from the top
	always_ff @(posedge clk) begin
		if (cmd.idx_init) begin
			idx_q <= count_q;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end
	end

	// Address arithmetic
	assign count_ext = CMPW'(count_q);
	assign pos_ext   = CMPW'(pos_q);
	assign idx_ext   = CMPW'(idx_q);
	assign pos_diff  = count_ext - pos_ext;
	assign slot      = pos_diff + CMPW'(1);
	assign count_m1  = count_q - CW'(1);
	assign idx_m2    = idx_q - CW'(2);

	always_comb begin
		unique case (cmd.wa_sel)
			WA_TOP:   waddr = count_q[AW-1:0];
			WA_POS:   waddr = pos_diff[AW-1:0];
			WA_SHIFT: waddr = idx_q[AW-1:0];
			WA_SLOT:  waddr = slot[AW-1:0];
			default:  waddr = count_q[AW-1:0];
		endcase
	end

	always_comb begin
		unique case (cmd.ra_sel)
			RA_BELOW_TOP: raddr = count_m1[AW-1:0];
			RA_POS:       raddr = pos_diff[AW-1:0];
			RA_SHIFT:     raddr = idx_m2[AW-1:0];
			default:      raddr = count_m1[AW-1:0];
		endcase
	end

	assign wdata = (cmd.wd_sel == WD_RAM) ? rdata : value_q;

	asi_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Capture the result word and status
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			data_q   <= cmd.res_from_ram ? rdata : '0;
			status_q <= cmd.res_status;
		end
	end

	// Status toward the controller
	assign st.kind       = kind_q;
	assign st.full       = (count_q == CW'(DEPTH));
	assign st.empty      = (count_q == '0);
	assign st.pos_ok     = (pos_ext != '0) && (pos_ext <= count_ext);
	assign st.pos_one    = (pos_q == POS_W'(1));
	assign st.shift_last = (({1'b0, idx_ext} + {1'b0, pos_ext}) ==
		({1'b0, count_ext} + (CMPW + 1)'(2)));

	assign data   = data_q;
	assign status = status_q;
	assign count  = count_ext[COUNT_W-1:0];

	// Fill level stays within the stack
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill level beyond depth");

	// Never remove from an empty stack
	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (count_q != '0))
		else $error("decrement of an empty stack");

endmodule

// ===== sv/asi_ctrl.sv =====
`timescale 1ns / 1ps

module asi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  asi_pkg::stat_t st,
	output asi_pkg::cmd_t  cmd
);

	import asi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_RDWAIT,
		S_SHIFT,
		S_WRVAL
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   m_tvalid_q;

	// Take a request only when idle and the result register is free
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;

	// Decode the request and sequence the datapath
	always_comb begin
		cmd          = '0;
		cmd.wa_sel   = WA_TOP;
		cmd.wd_sel   = WD_VALUE;
		cmd.ra_sel   = RA_BELOW_TOP;
		cmd.res_status = ST_OK;
		state_nx     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.load_req = 1'b1;
					state_nx     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nx = S_IDLE;
				unique case (st.kind)
					KIND_PUSH: begin
						cmd.res_load = 1'b1;
						if (st.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.ram_we  = 1'b1;
							cmd.wa_sel  = WA_TOP;
							cmd.cnt_inc = 1'b1;
						end
					end
					KIND_POP: begin
						if (st.empty) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.ra_sel  = RA_BELOW_TOP;
							cmd.cnt_dec = 1'b1;
							state_nx    = S_RDWAIT;
						end
					end
					KIND_PEEK: begin
						if (!st.pos_ok) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_BADPOS;
						end else begin
							cmd.ra_sel = RA_POS;
							state_nx   = S_RDWAIT;
						end
					end
					KIND_CHANGE: begin
						cmd.res_load = 1'b1;
						if (!st.pos_ok) begin
							cmd.res_status = ST_BADPOS;
						end else begin
							cmd.ram_we = 1'b1;
							cmd.wa_sel = WA_POS;
						end
					end
					KIND_INSERT: begin
						if (!st.pos_ok) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_BADPOS;
						end else if (st.full) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_FULL;
						end else if (st.pos_one) begin
							cmd.res_load = 1'b1;
							cmd.ram_we   = 1'b1;
							cmd.wa_sel   = WA_TOP;
							cmd.cnt_inc  = 1'b1;
						end else begin
							cmd.ra_sel   = RA_BELOW_TOP;
							cmd.idx_init = 1'b1;
							state_nx     = S_SHIFT;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.res_load     = 1'b1;
				cmd.res_from_ram = 1'b1;
				state_nx         = S_IDLE;
			end
			S_SHIFT: begin
				// Move one word up per cycle while reading the next one down
				cmd.ram_we = 1'b1;
				cmd.wa_sel = WA_SHIFT;
				cmd.wd_sel = WD_RAM;
				if (st.shift_last) begin
					state_nx = S_WRVAL;
				end else begin
					cmd.ra_sel  = RA_SHIFT;
					cmd.idx_dec = 1'b1;
				end
			end
			S_WRVAL: begin
				cmd.ram_we   = 1'b1;
				cmd.wa_sel   = WA_SLOT;
				cmd.cnt_inc  = 1'b1;
				cmd.res_load = 1'b1;
				state_nx     = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// No result is pending while a request is being worked on
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !m_tvalid_q)
		else $error("result pending during an operation");

	// An insert shift only runs with room left in the stack
	a_shift_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> !st.full)
		else $error("insert shift on a full stack");

	// An accepted request is decoded in the next cycle
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_DECIDE))
		else $error("accepted request not decoded");

endmodule

// ===== sv/array_stack_with_insert_top.sv =====
`timescale 1ns / 1ps

// LIFO stack of DEPTH signed 32-bit words held in a RAM with one write and
// one registered read port. Requests are push, pop, peek, change and insert
// at a 1-based position from the top; each gives one result with the data
// word, a status code and the fill level afterwards. Push, change, every
// rejected request and unused kinds are answered from the decode state;
// pop and peek wait in addition for the registered RAM read; an insert at
// position p greater than one first moves the entries above the insert
// point up one word per cycle through the RAM ports, then writes the value.
// One request is in work at a time; the next is taken once the block is
// back in idle and the previous result is taken or being taken.
// The stack contents are not cleared by reset; only the fill level is.
module array_stack_with_insert_top #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [asi_pkg::S_TDATA_W-1:0]   s_tdata,   // position[4:0], value[36:5]
	input  logic [asi_pkg::S_TUSER_W-1:0]   s_tuser,   // kind[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [asi_pkg::M_TDATA_W-1:0]   m_tdata,   // data[31:0], count[36:32]
	output logic [asi_pkg::M_TUSER_W-1:0]   m_tuser    // status[1:0]
);

	import asi_pkg::*;

	cmd_t                cmd;
	stat_t               st;
	logic [DATA_W-1:0]   data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;

	asi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	asi_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.kind     (s_tuser[KIND_W-1:0]),
		.position (s_tdata[POS_W-1:0]),
		.value    (s_tdata[POS_W +: VALUE_W]),
		.data     (data),
		.status   (status),
		.count    (count)
	);

	// Pack the result transfer
	assign m_tdata = {(M_TDATA_W - DATA_W - COUNT_W)'(0), count, data};
	assign m_tuser = status;

endmodule
